// ===== hdl/slii_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slii_pkg
// Types and fixed constants of the sorted leaf item directory.
// ----------------------------------------------------------------------------
package slii_pkg;

  localparam int OP_W    = 2;
  localparam int LEVEL_W = 8;
  localparam int OBJ_W   = 64;
  localparam int KIND_W  = 8;
  localparam int POS_W   = 64;
  localparam int SIZE_W  = 15;
  localparam int IDX_W   = 10;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 11;

  localparam int MAX_ENTRIES  = 1024;
  localparam int HEADER_BYTES = 101;
  localparam int ENTRY_BYTES  = 25;
  localparam logic [SIZE_W-1:0] NODE_SIZE_RESET = 15'd16384;

  localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [OBJ_W-1:0]  obj;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [SIZE_W-1:0] poff;
    logic [SIZE_W-1:0] psize;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [LEVEL_W-1:0] node_level;
    logic [OBJ_W-1:0]   key_object;
    logic [KIND_W-1:0]  key_kind;
    logic [POS_W-1:0]   key_position;
    logic [SIZE_W-1:0]  payload_offset;
    logic [SIZE_W-1:0]  payload_size;
    logic [IDX_W-1:0]   entry_index;
  } req_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [OBJ_W-1:0]  out_key_object;
    logic [KIND_W-1:0] out_key_kind;
    logic [POS_W-1:0]  out_key_position;
    logic [SIZE_W-1:0] out_payload_offset;
    logic [SIZE_W-1:0] out_payload_size;
    logic [SLOT_W-1:0] entry_count;
  } rsp_item_t;

  // true when key a lies strictly below key b
  function automatic logic key_below(entry_t a, entry_t b);
    logic r;
    if (a.obj != b.obj) begin
      r = a.obj < b.obj;
    end else if (a.kind != b.kind) begin
      r = a.kind < b.kind;
    end else begin
      r = a.pos < b.pos;
    end
    return r;
  endfunction

endpackage

// ===== hdl/slii_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slii_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface slii_req_if;
  import slii_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface slii_rsp_if;
  import slii_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/slii_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slii_mem
// Directory entry store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module slii_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  slii_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output slii_pkg::entry_t rdata
);
  import slii_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sorted_leaf_item_insert_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_leaf_item_insert_core
// Item directory of one B-tree leaf: begin, load, sorted insert and read.
// ----------------------------------------------------------------------------
// Begin, load and every rejected request finish in the cycle they are taken.
// A read fetches its entry when taken, captures it in S_RDW and passes it
// on from S_DONE. An insert whose new key lands at slot p scans the entry
// store upward with one read per cycle to find the upper bound, then shifts
// the tail with one read and one write per cycle, then writes the new entry,
// bound by the single read and single write port of the store.
// A finished response sits in an output register; the next request is taken
// as soon as that register is free or being drained.
module sorted_leaf_item_insert_core #(
  parameter int MAX_NODE_BYTES = 16384
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [slii_pkg::SIZE_W-1:0]   cfg_wr_data,
  slii_req_if.sink                      req,
  slii_rsp_if.source                    rsp
);
  import slii_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = CW + 6;
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_RDW   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state, state_next;
  logic [SIZE_W-1:0] node_size;
  logic [CW-1:0]     count, count_next;
  logic [SIZE_W-1:0] payload_floor, payload_floor_next;
  logic              is_leaf, is_leaf_next;
  logic [AW-1:0]     cur, cur_next;
  logic [AW-1:0]     pos, pos_next;
  entry_t            nent, nent_next;
  rsp_item_t         res, res_next;
  rsp_item_t         out_data, out_next;
  logic              out_valid, out_ld;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;

  slii_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  logic        out_free, acc;
  entry_t      in_ent;
  logic [SIZE_W-1:0] new_off;
  logic [EW-1:0]     dir_end;
  logic        ins_bad;
  rsp_item_t   err_rsp;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign acc       = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign in_ent.obj   = req.data.key_object;
  assign in_ent.kind  = req.data.key_kind;
  assign in_ent.pos   = req.data.key_position;
  assign in_ent.poff  = req.data.payload_offset;
  assign in_ent.psize = req.data.payload_size;

  assign new_off = payload_floor - req.data.payload_size;
  assign dir_end = EW'(HEADER_BYTES) + (EW'(count) + EW'(1)) * EW'(ENTRY_BYTES);
  assign ins_bad = (node_size == '0)
                || ({2'b00, node_size} > 17'(MAX_NODE_BYTES))
                || (req.data.payload_size == '0) || !is_leaf;

  always_comb begin
    err_rsp             = '0;
    err_rsp.entry_count = SLOT_W'(count);
  end

  always_comb begin
    state_next         = state;
    count_next         = count;
    payload_floor_next = payload_floor;
    is_leaf_next       = is_leaf;
    cur_next           = cur;
    pos_next           = pos;
    nent_next          = nent;
    res_next           = res;
    out_ld             = 1'b0;
    out_next           = err_rsp;
    mem_we             = 1'b0;
    mem_waddr          = cur;
    mem_wdata          = mem_rdata;
    mem_re             = 1'b0;
    mem_raddr          = cur;

    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (req.data.opcode)
            OP_BEGIN: begin
              out_ld             = 1'b1;
              out_next           = '0;
              count_next         = '0;
              is_leaf_next       = (req.data.node_level == '0);
              payload_floor_next = node_size;
            end
            OP_LOAD: begin
              out_ld = 1'b1;
              if (count >= MAX_CNT) begin
                out_next.status = ST_FULL;
              end else begin
                mem_we                      = 1'b1;
                mem_waddr                   = AW'(count);
                mem_wdata                   = in_ent;
                count_next                  = count + CW'(1);
                if (req.data.payload_offset < payload_floor) begin
                  payload_floor_next = req.data.payload_offset;
                end
                out_next.status             = ST_OK;
                out_next.slot               = SLOT_W'(count);
                out_next.out_key_object     = in_ent.obj;
                out_next.out_key_kind       = in_ent.kind;
                out_next.out_key_position   = in_ent.pos;
                out_next.out_payload_offset = in_ent.poff;
                out_next.out_payload_size   = in_ent.psize;
                out_next.entry_count        = SLOT_W'(count + CW'(1));
              end
            end
            OP_INSERT: begin
              if (ins_bad) begin
                out_ld          = 1'b1;
                out_next.status = ST_INVALID;
              end else if (req.data.payload_size > payload_floor) begin
                out_ld          = 1'b1;
                out_next.status = ST_NO_SPACE;
              end else if (EW'(new_off) < dir_end) begin
                out_ld          = 1'b1;
                out_next.status = ST_NO_SPACE;
              end else if (count >= MAX_CNT) begin
                out_ld          = 1'b1;
                out_next.status = ST_FULL;
              end else begin
                nent_next      = in_ent;
                nent_next.poff = new_off;
                if (count == '0) begin
                  pos_next   = '0;
                  state_next = S_PUT;
                end else begin
                  mem_re     = 1'b1;
                  mem_raddr  = '0;
                  cur_next   = '0;
                  state_next = S_SCAN;
                end
              end
            end
            OP_READ: begin
              if (XW'(req.data.entry_index) >= XW'(count)) begin
                out_ld          = 1'b1;
                out_next.status = ST_INVALID;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(req.data.entry_index);
                cur_next   = AW'(req.data.entry_index);
                state_next = S_RDW;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // upper bound: first stored key strictly above the new one
        if (key_below(nent, mem_rdata)) begin
          pos_next   = cur;
          mem_re     = 1'b1;
          mem_raddr  = AW'(count - CW'(1));
          cur_next   = AW'(count);
          state_next = S_SHIFT;
        end else if (CW'(cur) + CW'(1) == count) begin
          pos_next   = AW'(count);
          state_next = S_PUT;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = cur + AW'(1);
          cur_next   = cur + AW'(1);
        end
      end
      S_SHIFT: begin
        // move entry cur-1 up to cur, fetch the one below
        mem_we    = 1'b1;
        mem_waddr = cur;
        mem_wdata = mem_rdata;
        if (cur - AW'(1) == pos) begin
          state_next = S_PUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cur - AW'(2);
          cur_next  = cur - AW'(1);
        end
      end
      S_PUT: begin
        mem_we                      = 1'b1;
        mem_waddr                   = pos;
        mem_wdata                   = nent;
        count_next                  = count + CW'(1);
        payload_floor_next          = nent.poff;
        res_next.status             = ST_OK;
        res_next.slot               = SLOT_W'(pos);
        res_next.out_key_object     = nent.obj;
        res_next.out_key_kind       = nent.kind;
        res_next.out_key_position   = nent.pos;
        res_next.out_payload_offset = nent.poff;
        res_next.out_payload_size   = nent.psize;
        res_next.entry_count        = SLOT_W'(count + CW'(1));
        state_next                  = S_DONE;
      end
      S_RDW: begin
        res_next.status             = ST_OK;
        res_next.slot               = SLOT_W'(cur);
        res_next.out_key_object     = mem_rdata.obj;
        res_next.out_key_kind       = mem_rdata.kind;
        res_next.out_key_position   = mem_rdata.pos;
        res_next.out_payload_offset = mem_rdata.poff;
        res_next.out_payload_size   = mem_rdata.psize;
        res_next.entry_count        = SLOT_W'(count);
        state_next                  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_ld     = 1'b1;
          out_next   = res;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      node_size     <= NODE_SIZE_RESET;
      count         <= '0;
      payload_floor <= NODE_SIZE_RESET;
      is_leaf       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      payload_floor <= payload_floor_next;
      is_leaf       <= is_leaf_next;
      if (cfg_wr_en) begin
        node_size <= cfg_wr_data;
      end
      if (out_ld) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    pos  <= pos_next;
    nent <= nent_next;
    res  <= res_next;
    if (out_ld) begin
      out_data <= out_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("entry count above directory depth");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (mem_we && (mem_waddr > pos)))
    else $error("shift write at or below insert slot");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.status == ST_OK && rsp.data.entry_count != '0)
      |-> (rsp.data.slot < rsp.data.entry_count))
    else $error("ok response slot outside directory");

  a_no_take_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready)
    else $error("request taken while an operation runs");

endmodule
